[hw/rtl/ils_pkg.sv]
// Package for the indexed list stack: operation and status codes, the
// controller state type and the command and status structs between the
// controller and the datapath. Depends on nothing.
`default_nettype none

package ils_pkg;

  localparam int ModeW   = 3;
  localparam int StatusW = 2;

  // Operation codes carried on the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_POP_BACK  = 3'd1,
    MODE_INS_FRONT = 3'd2,
    MODE_INS_INDEX = 3'd3,
    MODE_REM_INDEX = 3'd4,
    MODE_QUERY     = 3'd5
  } mode_e;

  // Status codes returned with every result.
  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  // Class of work an operation needs.
  typedef enum logic [1:0] {
    CLS_QUERY  = 2'd0,
    CLS_INSERT = 2'd1,
    CLS_REMOVE = 2'd2
  } op_cls_e;

  // Read address selection for the entry memory.
  typedef enum logic [2:0] {
    RD_IDX   = 3'd0,
    RD_BELOW = 3'd1,
    RD_ABOVE = 3'd2,
    RD_FRONT = 3'd3,
    RD_BACK  = 3'd4
  } rd_sel_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE     = 4'd0,
    ST_CHECK    = 4'd1,
    ST_TAKE     = 4'd2,
    ST_TAKE_CAP = 4'd3,
    ST_MOVE     = 4'd4,
    ST_MOVE_WR  = 4'd5,
    ST_PUT      = 4'd6,
    ST_FRONT    = 4'd7,
    ST_BACK     = 4'd8,
    ST_BACK_CAP = 4'd9,
    ST_DONE     = 4'd10
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_req;
    rd_sel_e rd_sel;
    logic    wr_move;
    logic    wr_item;
    logic    idx_dec;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cap_removed;
    logic    cap_front;
    logic    cap_back;
    logic    clr_view;
  } ils_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_cls_e op_cls;
    logic    failed;
    logic    idx_above_tgt;
    logic    idx_below_last;
    logic    empty;
  } ils_stat_t;

endpackage

`default_nettype wire

[hw/rtl/ils_datapath.sv]
// Datapath of the indexed list stack: request registers, entry memory,
// shift index, fill count and result registers. Depends on ils_pkg.
`default_nettype none

module ils_datapath
  import ils_pkg::*;
#(
  parameter int Depth     = 16,
  parameter int ItemWidth = 32,
  localparam int CntW     = $clog2(Depth + 1),
  localparam int AddrW    = $clog2(Depth)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ils_cmd_t             cmd_i,
  output ils_stat_t            stat_o,
  input  wire [ModeW-1:0]      mode_i,
  input  wire [CntW-1:0]       position_i,
  input  wire [ItemWidth-1:0]  item_i,
  output logic [ItemWidth-1:0] removed_item_o,
  output logic                 removed_valid_o,
  output logic [StatusW-1:0]   status_o,
  output logic [CntW-1:0]      entry_count_o,
  output logic                 is_empty_o,
  output logic [ItemWidth-1:0] front_item_o,
  output logic [ItemWidth-1:0] back_item_o
);

  logic [ItemWidth-1:0] entry_mem_q [Depth];
  logic [ItemWidth-1:0] rdata_q;
  logic [AddrW-1:0]     raddr;
  logic [AddrW-1:0]     waddr;
  logic [ItemWidth-1:0] wdata;
  logic                 wen;

  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      tgt_q, tgt_d;
  logic [ItemWidth-1:0] item_q;
  op_cls_e              cls_q, cls_d;
  status_e              status_q, status_d;
  logic [ItemWidth-1:0] removed_q;
  logic                 removed_valid_q;
  logic [ItemWidth-1:0] front_q;
  logic [ItemWidth-1:0] back_q;

  logic full;
  logic empty;

  assign full  = (count_q >= CntW'(Depth));
  assign empty = (count_q == '0);

  // Decode a new request against the current fill count.
  always_comb begin
    cls_d    = CLS_QUERY;
    tgt_d    = '0;
    status_d = STAT_OK;
    case (mode_i)
      MODE_APPEND: begin
        cls_d = CLS_INSERT;
        tgt_d = count_q;
        if (full) status_d = STAT_FULL;
      end
      MODE_INS_FRONT: begin
        cls_d = CLS_INSERT;
        tgt_d = '0;
        if (full) status_d = STAT_FULL;
      end
      MODE_INS_INDEX: begin
        cls_d = CLS_INSERT;
        tgt_d = position_i;
        if (position_i > count_q) status_d = STAT_RANGE;
        else if (full)            status_d = STAT_FULL;
      end
      MODE_POP_BACK: begin
        cls_d = CLS_REMOVE;
        tgt_d = count_q - CntW'(1);
        if (empty) status_d = STAT_EMPTY;
      end
      MODE_REM_INDEX: begin
        cls_d = CLS_REMOVE;
        tgt_d = position_i;
        if (empty)                    status_d = STAT_EMPTY;
        else if (position_i >= count_q) status_d = STAT_RANGE;
      end
      default: begin
        cls_d = CLS_QUERY;
      end
    endcase
  end

  // Shift index: inserts walk down from the count, removals walk up from the target.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.latch_req) begin
      idx_d = (cls_d == CLS_INSERT) ? count_q : tgt_d;
    end else if (cmd_i.idx_dec) begin
      idx_d = idx_q - CntW'(1);
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  // Fill count update.
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc)      count_d = count_q + CntW'(1);
    else if (cmd_i.cnt_dec) count_d = count_q - CntW'(1);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      removed_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.latch_req)        removed_valid_q <= 1'b0;
      else if (cmd_i.cap_removed) removed_valid_q <= 1'b1;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.latch_req) begin
      tgt_q     <= tgt_d;
      item_q    <= item_i;
      cls_q     <= cls_d;
      status_q  <= status_d;
      removed_q <= '0;
    end
    if (cmd_i.cap_removed) removed_q <= rdata_q;
    if (cmd_i.clr_view) begin
      front_q <= '0;
      back_q  <= '0;
    end
    if (cmd_i.cap_front) front_q <= rdata_q;
    if (cmd_i.cap_back)  back_q  <= rdata_q;
  end

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:   raddr = idx_q[AddrW-1:0];
      RD_BELOW: raddr = idx_q[AddrW-1:0] - AddrW'(1);
      RD_ABOVE: raddr = idx_q[AddrW-1:0] + AddrW'(1);
      RD_FRONT: raddr = '0;
      RD_BACK:  raddr = count_q[AddrW-1:0] - AddrW'(1);
      default:  raddr = '0;
    endcase
  end

  // Write port: a shifted entry lands at the index, a new item at the target.
  assign wen   = cmd_i.wr_move | cmd_i.wr_item;
  assign waddr = cmd_i.wr_item ? tgt_q[AddrW-1:0] : idx_q[AddrW-1:0];
  assign wdata = cmd_i.wr_item ? item_q : rdata_q;

  // Entry memory with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wen) entry_mem_q[waddr] <= wdata;
    rdata_q <= entry_mem_q[raddr];
  end

  // Status towards the controller.
  assign stat_o.op_cls         = cls_q;
  assign stat_o.failed         = (status_q != STAT_OK);
  assign stat_o.idx_above_tgt  = (idx_q > tgt_q);
  assign stat_o.idx_below_last = ((idx_q + CntW'(1)) < count_q);
  assign stat_o.empty          = empty;

  // Result fields.
  assign removed_item_o  = removed_q;
  assign removed_valid_o = removed_valid_q;
  assign status_o        = status_q;
  assign entry_count_o   = count_q;
  assign is_empty_o      = empty;
  assign front_item_o    = front_q;
  assign back_item_o     = back_q;

endmodule

`default_nettype wire

[hw/rtl/ils_controller.sv]
// Controller of the indexed list stack: sequences reads, shifts and writes
// of the entry memory for one item at a time. Depends on ils_pkg.
`default_nettype none

module ils_controller
  import ils_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  output logic      busy,
  output logic      done_o,
  input  ils_stat_t stat_i,
  output ils_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.failed || stat_i.op_cls == CLS_QUERY) state_d = ST_FRONT;
        else if (stat_i.op_cls == CLS_INSERT)            state_d = ST_MOVE;
        else                                             state_d = ST_TAKE;
      end
      ST_TAKE:     state_d = ST_TAKE_CAP;
      ST_TAKE_CAP: state_d = ST_MOVE;
      ST_MOVE: begin
        if (stat_i.op_cls == CLS_INSERT) begin
          state_d = stat_i.idx_above_tgt ? ST_MOVE_WR : ST_PUT;
        end else begin
          state_d = stat_i.idx_below_last ? ST_MOVE_WR : ST_FRONT;
        end
      end
      ST_MOVE_WR:  state_d = ST_MOVE;
      ST_PUT:      state_d = ST_FRONT;
      ST_FRONT:    state_d = stat_i.empty ? ST_DONE : ST_BACK;
      ST_BACK:     state_d = ST_BACK_CAP;
      ST_BACK_CAP: state_d = ST_DONE;
      ST_DONE:     state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Commands for the datapath.
  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RD_IDX;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch_req = start;
      end
      ST_TAKE: begin
        cmd_o.rd_sel = RD_IDX;
      end
      ST_TAKE_CAP: begin
        cmd_o.cap_removed = 1'b1;
      end
      ST_MOVE: begin
        if (stat_i.op_cls == CLS_INSERT) begin
          cmd_o.rd_sel = RD_BELOW;
        end else begin
          cmd_o.rd_sel  = RD_ABOVE;
          cmd_o.cnt_dec = !stat_i.idx_below_last;
        end
      end
      ST_MOVE_WR: begin
        cmd_o.wr_move = 1'b1;
        cmd_o.idx_dec = (stat_i.op_cls == CLS_INSERT);
        cmd_o.idx_inc = (stat_i.op_cls == CLS_REMOVE);
      end
      ST_PUT: begin
        cmd_o.wr_item = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_FRONT: begin
        cmd_o.rd_sel   = RD_FRONT;
        cmd_o.clr_view = stat_i.empty;
      end
      ST_BACK: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_sel    = RD_BACK;
      end
      ST_BACK_CAP: begin
        cmd_o.cap_back = 1'b1;
      end
      default: begin
        cmd_o.rd_sel = RD_IDX;
      end
    endcase
  end

  // Handshake outputs.
  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

[hw/rtl/indexed_list_stack.sv]
// Indexed list stack: the done_o strobe follows the check, any shifts and the view reads
// of the accepted item; the next item can be accepted in the cycle after done_o.
// Each shift is a read state, then a write state: the entry memory read is registered.
// Results are held for the one cycle of done_o and cannot be stalled.
// Reset empties the list at once; memory contents stay undefined until written.
// Top level: joins the controller and the datapath. Depends on ils_pkg.
`default_nettype none

module indexed_list_stack
  import ils_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  output logic                  busy,
  input  wire [ModeW-1:0]       mode_i,
  input  wire [CntW-1:0]        position_i,
  input  wire [ITEM_WIDTH-1:0]  item_i,
  output logic                  done_o,
  output logic [ITEM_WIDTH-1:0] removed_item_o,
  output logic                  removed_valid_o,
  output logic [StatusW-1:0]    status_o,
  output logic [CntW-1:0]       entry_count_o,
  output logic                  is_empty_o,
  output logic [ITEM_WIDTH-1:0] front_item_o,
  output logic [ITEM_WIDTH-1:0] back_item_o
);

  ils_cmd_t  cmd;
  ils_stat_t stat;

  // Sequencer.
  ils_controller u_ctl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Storage and result registers.
  ils_datapath #(
    .Depth     (DEPTH),
    .ItemWidth (ITEM_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .item_i          (item_i),
    .removed_item_o  (removed_item_o),
    .removed_valid_o (removed_valid_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o),
    .front_item_o    (front_item_o),
    .back_item_o     (back_item_o)
  );

endmodule

`default_nettype wire

[hw/rtl/ils_checker.sv]
// Port checker for the indexed list stack and the bind that attaches it.
// Depends on ils_pkg and on the indexed_list_stack top level.
`default_nettype none

module ils_checker
  import ils_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  start,
  input wire                  busy,
  input wire                  done_o,
  input wire [ITEM_WIDTH-1:0] removed_item_o,
  input wire                  removed_valid_o,
  input wire [StatusW-1:0]    status_o,
  input wire [CntW-1:0]       entry_count_o,
  input wire                  is_empty_o,
  input wire [ITEM_WIDTH-1:0] front_item_o,
  input wire [ITEM_WIDTH-1:0] back_item_o
);

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result strobe lasts one cycle and leads back to idle.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy))
    else $error("result strobe longer than one cycle");

  // An empty list shows zero front and back items.
  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |-> (front_item_o == '0 && back_item_o == '0 &&
                                entry_count_o == '0))
    else $error("empty list shows entries");

  // A removed entry comes only with an OK status, and otherwise reads zero.
  a_removed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (removed_valid_o ? (status_o == STAT_OK) : (removed_item_o == '0)))
    else $error("removed item inconsistent with status");

endmodule

bind indexed_list_stack ils_checker #(
  .DEPTH      (DEPTH),
  .ITEM_WIDTH (ITEM_WIDTH)
) u_ils_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .removed_item_o  (removed_item_o),
  .removed_valid_o (removed_valid_o),
  .status_o        (status_o),
  .entry_count_o   (entry_count_o),
  .is_empty_o      (is_empty_o),
  .front_item_o    (front_item_o),
  .back_item_o     (back_item_o)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for indexed_list_stack: directed and random list
// operations are predicted in step and every result is compared field by field.
// Depends on ils_pkg and the indexed_list_stack RTL.
`default_nettype none

module tb;
  import ils_pkg::*;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int CntW       = $clog2(DEPTH + 1);
  localparam int StallLimit = 2000;
  localparam int TailCycles = 64;
  localparam int MaxGap     = 16;

  // Mode values outside the defined operations; the block treats them as a query.
  localparam logic [ModeW-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_B = 3'd7;

  typedef struct {
    logic [ITEM_WIDTH-1:0] removed_item;
    logic                  removed_valid;
    status_e               status;
    logic [CntW-1:0]       entry_count;
    logic                  is_empty;
    logic [ITEM_WIDTH-1:0] front_item;
    logic [ITEM_WIDTH-1:0] back_item;
  } list_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ModeW-1:0]      mode_i = '0;
  logic [CntW-1:0]       position_i = '0;
  logic [ITEM_WIDTH-1:0] item_i = '0;
  logic                  done_o;
  logic [ITEM_WIDTH-1:0] removed_item_o;
  logic                  removed_valid_o;
  logic [StatusW-1:0]    status_o;
  logic [CntW-1:0]       entry_count_o;
  logic                  is_empty_o;
  logic [ITEM_WIDTH-1:0] front_item_o;
  logic [ITEM_WIDTH-1:0] back_item_o;

  // Predicted list contents and the results still to come from the block.
  logic [ITEM_WIDTH-1:0] list_entries [DEPTH];
  int                    list_fill = 0;
  list_result_t          pending_results [$];
  int                    mismatches = 0;
  int                    idle_cycles = 0;
  bit                    burst_mode = 1'b0;

  indexed_list_stack #(
    .DEPTH     (DEPTH),
    .ITEM_WIDTH(ITEM_WIDTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .item_i         (item_i),
    .done_o         (done_o),
    .removed_item_o (removed_item_o),
    .removed_valid_o(removed_valid_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .front_item_o   (front_item_o),
    .back_item_o    (back_item_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Applies one operation to the predicted list and returns the expected result.
  function automatic list_result_t apply_list_op(logic [ModeW-1:0] op, logic [CntW-1:0] pos,
                                                 logic [ITEM_WIDTH-1:0] word);
    list_result_t res;
    int           at;
    int           i;
    res.removed_item  = '0;
    res.removed_valid = 1'b0;
    res.status        = STAT_OK;
    case (op)
      MODE_APPEND, MODE_INS_FRONT, MODE_INS_INDEX: begin
        if (op == MODE_APPEND) at = list_fill;
        else if (op == MODE_INS_FRONT) at = 0;
        else at = int'(pos);
        // The position check comes before the full check.
        if (at > list_fill) begin
          res.status = STAT_RANGE;
        end else if (list_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (i = list_fill; i > at; i--) list_entries[i] = list_entries[i-1];
          list_entries[at] = word;
          list_fill++;
        end
      end
      MODE_POP_BACK, MODE_REM_INDEX: begin
        at = (op == MODE_POP_BACK) ? list_fill - 1 : int'(pos);
        if (list_fill == 0) begin
          res.status = STAT_EMPTY;
        end else if (at >= list_fill) begin
          res.status = STAT_RANGE;
        end else begin
          res.removed_item  = list_entries[at];
          res.removed_valid = 1'b1;
          for (i = at; i + 1 < list_fill; i++) list_entries[i] = list_entries[i+1];
          list_fill--;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = list_fill[CntW-1:0];
    res.is_empty    = (list_fill == 0);
    res.front_item  = (list_fill != 0) ? list_entries[0] : '0;
    res.back_item   = (list_fill != 0) ? list_entries[list_fill-1] : '0;
    return res;
  endfunction

  // Sends one item after a random gap and records its expected result on acceptance.
  task automatic send_item(logic [ModeW-1:0] op, logic [CntW-1:0] pos,
                           logic [ITEM_WIDTH-1:0] word);
    int           gap;
    list_result_t exp_res;
    gap = burst_mode ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= op;
    position_i <= pos;
    item_i     <= word;
    do @(posedge clk_i); while (busy);
    exp_res         = apply_list_op(op, pos, word);
    pending_results = {pending_results, exp_res};
  endtask

  function automatic logic [ITEM_WIDTH-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Operations on an empty list, a bad insert position and the spare mode values.
  task automatic test_empty_list();
    send_item(MODE_QUERY, 5'd0, 32'h0000_0000);
    send_item(MODE_POP_BACK, 5'd0, 32'hFFFF_FFFF);
    send_item(MODE_REM_INDEX, 5'd0, 32'h0000_0000);
    send_item(MODE_INS_INDEX, 5'd1, 32'h1234_5678);
    send_item(MODE_SPARE_A, 5'd31, 32'hFFFF_FFFF);
    send_item(MODE_SPARE_B, 5'd16, 32'hFFFF_FFFF);
  endtask

  // Fills the list with every kind of insert, including extreme item words.
  task automatic test_fill_to_full();
    send_item(MODE_APPEND, 5'd0, 32'h0000_0000);
    send_item(MODE_APPEND, 5'd31, 32'hFFFF_FFFF);
    send_item(MODE_INS_FRONT, 5'd0, 32'hA5A5_A5A5);
    send_item(MODE_INS_INDEX, 5'd3, 32'h5A5A_5A5A);
    send_item(MODE_INS_INDEX, 5'd0, 32'h8000_0001);
    send_item(MODE_INS_INDEX, 5'd2, 32'h7FFF_FFFE);
    while (list_fill < DEPTH) begin
      case (list_fill % 3)
        0: send_item(MODE_APPEND, 5'd0, pick_word());
        1: send_item(MODE_INS_FRONT, 5'd0, pick_word());
        default: send_item(MODE_INS_INDEX, CntW'($urandom_range(0, list_fill)), pick_word());
      endcase
    end
  endtask

  // Inserts into a full list and out-of-range positions on a full list.
  task automatic test_full_list();
    send_item(MODE_APPEND, 5'd0, 32'hDEAD_BEEF);
    send_item(MODE_INS_FRONT, 5'd0, 32'hDEAD_BEEF);
    send_item(MODE_INS_INDEX, 5'd16, 32'hDEAD_BEEF);
    send_item(MODE_INS_INDEX, 5'd17, 32'hDEAD_BEEF);
    send_item(MODE_REM_INDEX, 5'd16, 32'h0000_0000);
  endtask

  // Random phases that lean towards filling, draining or churning the list,
  // with some noise of queries, spare modes and bad positions.
  task automatic test_random_sequences(int num_items);
    int phase_left;
    int phase_kind;
    int ins_pct;
    int r;
    int sel;
    phase_left = 0;
    ins_pct    = 50;
    for (int n = 0; n < num_items; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 45);
        phase_kind = $urandom_range(0, 2);
        ins_pct    = (phase_kind == 0) ? 75 : (phase_kind == 1) ? 20 : 48;
        burst_mode = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r   = $urandom_range(0, 99);
      sel = $urandom_range(0, 2);
      if (r >= 90) begin
        case (sel)
          0: send_item(MODE_QUERY, CntW'($urandom), $urandom);
          1: send_item($urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B,
                       CntW'($urandom), $urandom);
          default: send_item($urandom_range(0, 1) ? MODE_INS_INDEX : MODE_REM_INDEX,
                             CntW'($urandom_range(list_fill, 31)), pick_word());
        endcase
      end else if (r < ins_pct) begin
        case (sel)
          0: send_item(MODE_APPEND, CntW'($urandom), pick_word());
          1: send_item(MODE_INS_FRONT, CntW'($urandom), pick_word());
          default: send_item(MODE_INS_INDEX, CntW'($urandom_range(0, list_fill)), pick_word());
        endcase
      end else begin
        if (sel == 0 || list_fill == 0) begin
          send_item(MODE_POP_BACK, CntW'($urandom), $urandom);
        end else begin
          send_item(MODE_REM_INDEX, CntW'($urandom_range(0, list_fill - 1)), $urandom);
        end
      end
    end
    burst_mode = 1'b0;
  endtask

  task automatic check_field(string name, logic [ITEM_WIDTH-1:0] want,
                             logic [ITEM_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compares every result strobe with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no item outstanding, expected none, got status %h",
                 $time, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("removed_item", want.removed_item, removed_item_o);
        check_field("removed_valid", ITEM_WIDTH'(want.removed_valid),
                    ITEM_WIDTH'(removed_valid_o));
        check_field("status", ITEM_WIDTH'(want.status), ITEM_WIDTH'(status_o));
        check_field("entry_count", ITEM_WIDTH'(want.entry_count),
                    ITEM_WIDTH'(entry_count_o));
        check_field("is_empty", ITEM_WIDTH'(want.is_empty), ITEM_WIDTH'(is_empty_o));
        check_field("front_item", want.front_item, front_item_o);
        check_field("back_item", want.back_item, back_item_o);
      end
    end
  end

  // Ends the run if neither an item nor a result is accepted for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_fill_to_full();
    test_full_list();
    test_random_sequences(620);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/ils_pkg.sv
hw/rtl/ils_datapath.sv
hw/rtl/ils_controller.sv
hw/rtl/indexed_list_stack.sv
hw/rtl/ils_checker.sv
dv/tb.sv
